// File: hdl/vvr_pkg.sv
// ----------------------------------------------------------------------------
// vvr_pkg
// Shared widths, constants and types for the windowed vibration RMS block.
// ----------------------------------------------------------------------------
package vvr_pkg;

    localparam int AccelW  = 16;   // signed Q8 acceleration per axis
    localparam int TimeW   = 32;   // timestamp, microseconds
    localparam int WinW    = 11;   // window length / sample count
    localparam int DispW   = 8;    // display decimation
    localparam int SqW     = 32;   // x^2 + y^2 + z^2 (<= 3 * 2^30)
    localparam int SumW    = 42;   // window sum of squares
    localparam int RootW   = 16;   // magnitude / rms
    localparam int StepW   = 6;    // sequencer step counter
    localparam int CfgIdxW = 1;

    localparam int InDataW  = 3 * AccelW + TimeW;         // 80
    localparam int OutRawW  = 2 * RootW + WinW;            // 43
    localparam int OutDataW = ((OutRawW + 7) / 8) * 8;    // 48
    localparam int OutPadW  = OutDataW - OutRawW;

    localparam logic [WinW-1:0]  WindowMax         = 11'd1024;
    localparam logic [WinW-1:0]  WindowLengthReset = 11'd200;
    localparam logic [DispW-1:0] DisplayEveryReset = 8'd10;

    // first trial bit of the digit-by-digit square root over SqW bits
    localparam logic [SqW-1:0] SqrtBitInit = 32'h4000_0000;

    localparam logic [StepW-1:0] SquareLast = 6'd3;
    localparam logic [StepW-1:0] SqrtLast   = 6'd15;
    localparam logic [StepW-1:0] DivLast    = 6'd41;

    typedef enum logic [CfgIdxW-1:0] {
        REG_WINDOW_LENGTH = 1'b0,
        REG_DISPLAY_EVERY = 1'b1
    } cfg_reg_t;

    // one classified sample on its way from front to back
    typedef struct packed {
        logic signed [AccelW-1:0] accel_x;
        logic signed [AccelW-1:0] accel_y;
        logic signed [AccelW-1:0] accel_z;
        logic                     show_sample;
        logic                     window_done;
        logic [WinW-1:0]          window_samples;
    } vvr_entry_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_MAG,
        BK_DIV,
        BK_ROOT,
        BK_OUT
    } back_state_t;

endpackage

// File: hdl/vector_vibration_rms.sv
// Processing: a kept sample runs three squares and a root for its magnitude; a sample
//   that closes a window also runs a 42-step divide and a second root.
// The back sequencer works on one sample at a time with its shared bit-serial
//   square root and restoring divider; the queue holds samples that wait for it.
// Reset: synchronous, active low; clears counts, window sum, last timestamp and
//   queue, and loads window_length = 200, display_every = 10.
// ----------------------------------------------------------------------------
// vector_vibration_rms
// Three-axis vibration monitor: per-sample vector magnitude and windowed RMS.
// ----------------------------------------------------------------------------
module vector_vibration_rms (
    input  logic                          aclk,
    input  logic                          aresetn,

    // sample requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32], sample_time[79:48]
    input  logic [vvr_pkg::InDataW-1:0]   s_tdata,
    // sample_ok[0]
    input  logic [0:0]                    s_tuser,

    // results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // magnitude[15:0], window_rms[31:16], window_samples[42:32], zero pad
    output logic [vvr_pkg::OutDataW-1:0]  m_tdata,
    // show_sample[0], window_done[1]
    output logic [1:0]                    m_tuser,

    // configuration: 0 = window_length, 1 = display_every
    input  logic                          cfg_we,
    input  logic [vvr_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [vvr_pkg::WinW-1:0]      cfg_wdata
);

    // front -> queue -> back
    logic                q_push;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    vvr_pkg::vvr_entry_t q_in;
    vvr_pkg::vvr_entry_t q_out;

    // Front filters invalid and repeated timestamps and decides the display
    // and window-close flags up front, since they do not depend on the data.
    vvr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_push    (q_push),
        .q_entry   (q_in),
        .q_full    (q_full)
    );

    // Short queue lets the front keep taking requests while the back works
    // or its result waits for m_tready.
    vvr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .valid      (q_valid),
        .pop        (q_pop),
        .pop_entry  (q_out)
    );

    // Back: one multiplier for the three squares, window sum, shared root
    // unit for magnitude and RMS, divider for sum / count on window close.
    vvr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: hdl/vvr_queue.sv
// ----------------------------------------------------------------------------
// vvr_queue
// Two-entry request queue between the front and the back.
// ----------------------------------------------------------------------------
module vvr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  vvr_pkg::vvr_entry_t push_entry,
    output logic                full,
    output logic                valid,
    input  logic                pop,
    output vvr_pkg::vvr_entry_t pop_entry
);

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);
    localparam int CntW  = $clog2(Depth + 1);
    localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

    vvr_pkg::vvr_entry_t slot_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [CntW-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full      = (count_reg == DepthCnt);
    assign valid     = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: hdl/vvr_front.sv
// ----------------------------------------------------------------------------
// vvr_front
// Input side: filters samples, keeps window and display counts, holds the
// configuration registers and pushes classified requests to the queue.
// ----------------------------------------------------------------------------
module vvr_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vvr_pkg::InDataW-1:0]   s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          cfg_we,
    input  logic [vvr_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [vvr_pkg::WinW-1:0]      cfg_wdata,
    output logic                          q_push,
    output vvr_pkg::vvr_entry_t           q_entry,
    input  logic                          q_full
);

    logic [vvr_pkg::WinW-1:0]  window_length_reg;
    logic [vvr_pkg::DispW-1:0] display_every_reg;
    logic [vvr_pkg::TimeW-1:0] last_time_reg;
    logic [vvr_pkg::WinW-1:0]  window_count_reg;
    logic [vvr_pkg::DispW-1:0] display_count_reg;

    logic [vvr_pkg::TimeW-1:0] sample_time;
    logic                      keep;
    logic [vvr_pkg::WinW-1:0]  window_count_inc;
    logic [vvr_pkg::WinW-1:0]  limit;
    logic                      done;
    logic [vvr_pkg::DispW-1:0] display_count_inc;
    logic                      show;

    assign s_tready    = !q_full;
    assign sample_time = s_tdata[3*vvr_pkg::AccelW +: vvr_pkg::TimeW];

    // dropped: invalid report, or same timestamp as the last kept one
    assign keep = s_tvalid && s_tready && s_tuser[0] && (sample_time != last_time_reg);

    assign window_count_inc  = window_count_reg + 1'b1;
    assign limit             = (window_length_reg > vvr_pkg::WindowMax) ?
                               vvr_pkg::WindowMax : window_length_reg;
    assign done              = (window_count_inc >= limit);
    assign display_count_inc = display_count_reg + 1'b1;
    assign show              = (display_count_inc >= display_every_reg);

    assign q_push                 = keep;
    assign q_entry.accel_x        = signed'(s_tdata[0 +: vvr_pkg::AccelW]);
    assign q_entry.accel_y        = signed'(s_tdata[vvr_pkg::AccelW +: vvr_pkg::AccelW]);
    assign q_entry.accel_z        = signed'(s_tdata[2*vvr_pkg::AccelW +: vvr_pkg::AccelW]);
    assign q_entry.show_sample    = show;
    assign q_entry.window_done    = done;
    assign q_entry.window_samples = done ? window_count_inc : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= vvr_pkg::WindowLengthReset;
            display_every_reg <= vvr_pkg::DisplayEveryReset;
        end else if (cfg_we) begin
            case (vvr_pkg::cfg_reg_t'(cfg_index))
                vvr_pkg::REG_WINDOW_LENGTH: window_length_reg <= cfg_wdata;
                vvr_pkg::REG_DISPLAY_EVERY: display_every_reg <= cfg_wdata[vvr_pkg::DispW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg     <= '0;
            window_count_reg  <= '0;
            display_count_reg <= '0;
        end else if (keep) begin
            last_time_reg     <= sample_time;
            window_count_reg  <= done ? '0 : window_count_inc;
            display_count_reg <= show ? '0 : display_count_inc;
        end
    end

endmodule

// File: hdl/vvr_back.sv
// ----------------------------------------------------------------------------
// vvr_back
// Execution side: squares, window sum, shared bit-serial square root,
// restoring divider and the output register.
// ----------------------------------------------------------------------------
module vvr_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  vvr_pkg::vvr_entry_t           q_entry,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [vvr_pkg::OutDataW-1:0]  m_tdata,
    output logic [1:0]                    m_tuser
);

    vvr_pkg::back_state_t state_reg, state_next;
    logic [vvr_pkg::StepW-1:0] step_reg, step_next;

    vvr_pkg::vvr_entry_t ent_reg;
    logic [vvr_pkg::SqW-1:0]   prod_reg;
    logic [vvr_pkg::SqW-1:0]   sq_reg;
    logic [vvr_pkg::SumW-1:0]  sum_reg;
    logic [vvr_pkg::SqW-1:0]   rad_reg;
    logic [vvr_pkg::SqW-1:0]   res_reg;
    logic [vvr_pkg::SqW-1:0]   bit_reg;
    logic [vvr_pkg::SumW-1:0]  quo_reg;
    logic [vvr_pkg::WinW-1:0]  rem_reg;
    logic [vvr_pkg::RootW-1:0] mag_reg;
    logic [vvr_pkg::RootW-1:0] rms_reg;

    logic                           m_tvalid_reg;
    logic [vvr_pkg::OutDataW-1:0]   m_tdata_reg;
    logic [1:0]                     m_tuser_reg;

    logic out_free;
    logic out_load;
    logic step_last;

    // squarer
    logic signed [vvr_pkg::AccelW-1:0] axis;
    logic signed [vvr_pkg::SqW-1:0]    prod;
    logic [vvr_pkg::SqW-1:0]           sq_total;

    // square root step
    logic [vvr_pkg::SqW:0]   sqrt_try;
    logic                    sqrt_take;
    logic [vvr_pkg::SqW-1:0] rad_step;
    logic [vvr_pkg::SqW-1:0] res_step;

    // divider step
    logic [vvr_pkg::WinW:0]    div_try;
    logic [vvr_pkg::WinW:0]    div_diff;
    logic                      div_take;
    logic [vvr_pkg::WinW-1:0]  rem_step;
    logic [vvr_pkg::SumW-1:0]  quo_step;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        case (step_reg[1:0])
            2'd0:    axis = ent_reg.accel_x;
            2'd1:    axis = ent_reg.accel_y;
            default: axis = ent_reg.accel_z;
        endcase
    end

    assign prod     = axis * axis;
    assign sq_total = sq_reg + prod_reg;

    assign sqrt_try  = {1'b0, res_reg} + {1'b0, bit_reg};
    assign sqrt_take = ({1'b0, rad_reg} >= sqrt_try);
    assign rad_step  = sqrt_take ? (rad_reg - sqrt_try[vvr_pkg::SqW-1:0]) : rad_reg;
    assign res_step  = sqrt_take ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);

    assign div_try  = {rem_reg, quo_reg[vvr_pkg::SumW-1]};
    assign div_take = (div_try >= {1'b0, ent_reg.window_samples});
    assign div_diff = div_try - {1'b0, ent_reg.window_samples};
    assign rem_step = div_take ? div_diff[vvr_pkg::WinW-1:0] : div_try[vvr_pkg::WinW-1:0];
    assign quo_step = {quo_reg[vvr_pkg::SumW-2:0], div_take};

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            vvr_pkg::BK_IDLE: begin
                if (q_valid) state_next = vvr_pkg::BK_SQUARE;
            end
            vvr_pkg::BK_SQUARE: begin
                if (step_reg == vvr_pkg::SquareLast) state_next = vvr_pkg::BK_MAG;
            end
            vvr_pkg::BK_MAG: begin
                if (step_reg == vvr_pkg::SqrtLast) begin
                    state_next = ent_reg.window_done ? vvr_pkg::BK_DIV : vvr_pkg::BK_OUT;
                end
            end
            vvr_pkg::BK_DIV: begin
                if (step_reg == vvr_pkg::DivLast) state_next = vvr_pkg::BK_ROOT;
            end
            vvr_pkg::BK_ROOT: begin
                if (step_reg == vvr_pkg::SqrtLast) state_next = vvr_pkg::BK_OUT;
            end
            vvr_pkg::BK_OUT: begin
                if (out_free) state_next = vvr_pkg::BK_IDLE;
            end
            default: state_next = vvr_pkg::BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop     = 1'b0;
        out_load  = 1'b0;
        step_last = 1'b0;
        case (state_reg)
            vvr_pkg::BK_IDLE: q_pop = q_valid;
            vvr_pkg::BK_MAG:  step_last = (step_reg == vvr_pkg::SqrtLast);
            vvr_pkg::BK_DIV:  step_last = (step_reg == vvr_pkg::DivLast);
            vvr_pkg::BK_ROOT: step_last = (step_reg == vvr_pkg::SqrtLast);
            vvr_pkg::BK_OUT:  out_load = out_free;
            default: ;
        endcase
    end

    assign step_next = (state_next != state_reg) ? '0 : step_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= vvr_pkg::BK_IDLE;
            step_reg     <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == vvr_pkg::BK_SQUARE && step_reg == vvr_pkg::SquareLast) begin
                sum_reg <= sum_reg + {{(vvr_pkg::SumW-vvr_pkg::SqW){1'b0}}, sq_total};
            end else if (state_reg == vvr_pkg::BK_DIV && step_last) begin
                sum_reg <= '0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ent_reg <= q_entry;
        end
        case (state_reg)
            vvr_pkg::BK_SQUARE: begin
                if (step_reg != vvr_pkg::SquareLast) begin
                    prod_reg <= $unsigned(prod);
                end
                if (step_reg == 6'd1) begin
                    sq_reg <= prod_reg;
                end else if (step_reg == 6'd2) begin
                    sq_reg <= sq_total;
                end
                if (step_reg == vvr_pkg::SquareLast) begin
                    rad_reg <= sq_total;
                    res_reg <= '0;
                    bit_reg <= vvr_pkg::SqrtBitInit;
                end
            end
            vvr_pkg::BK_MAG: begin
                rad_reg <= rad_step;
                res_reg <= res_step;
                bit_reg <= bit_reg >> 2;
                if (step_last) begin
                    mag_reg <= res_step[vvr_pkg::RootW-1:0];
                    quo_reg <= sum_reg;
                    rem_reg <= '0;
                end
            end
            vvr_pkg::BK_DIV: begin
                rem_reg <= rem_step;
                quo_reg <= quo_step;
                if (step_last) begin
                    // mean of squares stays at or below 3 * 2^30
                    rad_reg <= quo_step[vvr_pkg::SqW-1:0];
                    res_reg <= '0;
                    bit_reg <= vvr_pkg::SqrtBitInit;
                end
            end
            vvr_pkg::BK_ROOT: begin
                rad_reg <= rad_step;
                res_reg <= res_step;
                bit_reg <= bit_reg >> 2;
                if (step_last) begin
                    rms_reg <= res_step[vvr_pkg::RootW-1:0];
                end
            end
            default: ;
        endcase
        if (out_load) begin
            m_tdata_reg <= {{vvr_pkg::OutPadW{1'b0}},
                            ent_reg.window_samples,
                            ent_reg.window_done ? rms_reg : {vvr_pkg::RootW{1'b0}},
                            mag_reg};
            m_tuser_reg <= {ent_reg.window_done, ent_reg.show_sample};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vector_vibration_rms: drives sample requests with
// random gaps, mirrors the magnitude / window RMS arithmetic in a local model
// and compares every result field by field while the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb;
    import vvr_pkg::*;

    localparam int CycleLimit  = 1_000_000;
    localparam int QuietCycles = 100;     // longer than a window close in the back end
    localparam int IdlePct     = 19;

    // one sample request as the sender sees it
    typedef struct {
        logic signed [AccelW-1:0] ax;
        logic signed [AccelW-1:0] ay;
        logic signed [AccelW-1:0] az;
        logic [TimeW-1:0]         stamp;
        logic                     ok;
    } sample_req_t;

    // one result as predicted
    typedef struct {
        logic [RootW-1:0] magnitude;
        logic             show;
        logic             done;
        logic [RootW-1:0] rms;
        logic [WinW-1:0]  samples;
    } reading_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [InDataW-1:0]   s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [OutDataW-1:0]  m_tdata;
    logic [1:0]           m_tuser;
    logic                 cfg_we    = 1'b0;
    cfg_reg_t             cfg_index = REG_WINDOW_LENGTH;
    logic [WinW-1:0]      cfg_wdata = '0;

    sample_req_t pending_samples[$];
    reading_t    expected_readings[$];

    // sender/receiver pacing, changed by the sequence below
    int  idle_pct   = IdlePct;
    bit  hold_sends = 1'b0;

    // local copy of the block's state and registers
    logic [WinW-1:0]  win_len    = WindowLengthReset;
    logic [DispW-1:0] disp_every = DisplayEveryReset;
    logic [TimeW-1:0] last_stamp = '0;
    logic [63:0]      win_sum    = '0;
    logic [WinW-1:0]  win_cnt    = '0;
    logic [DispW-1:0] disp_cnt   = '0;

    // generator's idea of the last accepted timestamp
    logic [TimeW-1:0] gen_stamp = '0;

    int fault_count  = 0;
    int n_accepted   = 0;
    int n_dropped    = 0;
    int n_checked    = 0;
    int n_windows    = 0;
    int n_settings   = 1;
    int cycle_count  = 0;

    vector_vibration_rms i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // arithmetic of the model
    // ------------------------------------------------------------------
    function automatic logic [63:0] axis_power(logic signed [AccelW-1:0] a);
        longint v;
        v = a;
        return v * v;
    endfunction

    // floor square root, one result bit per trial from the top down
    function automatic logic [31:0] floor_root(logic [63:0] n);
        logic [31:0] r;
        logic [31:0] c;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            c = r | (32'd1 << b);
            if ({32'd0, c} * {32'd0, c} <= n) r = c;
        end
        return r;
    endfunction

    // an accepted request: drop invalid / repeated stamps, else queue a reading
    task automatic predict_reading(logic [InDataW-1:0] d, logic ok);
        logic [TimeW-1:0] ts;
        logic [63:0]      sq;
        logic [WinW-1:0]  limit;
        reading_t         r;
        ts = d[3*AccelW +: TimeW];
        if (!ok || ts == last_stamp) begin
            n_dropped++;
            return;
        end
        n_accepted++;
        last_stamp = ts;
        sq = axis_power(d[0 +: AccelW]) + axis_power(d[AccelW +: AccelW])
           + axis_power(d[2*AccelW +: AccelW]);
        win_sum += sq;
        win_cnt++;
        disp_cnt = disp_cnt + 1'b1;          // 8-bit wrap
        r.show = (disp_cnt >= disp_every);   // display_every 0 flags every sample
        if (r.show) disp_cnt = '0;
        // length 0 closes on every sample; above max saturates
        limit = (win_len > WindowMax) ? WindowMax : win_len;
        r.done    = (win_cnt >= limit);
        r.rms     = '0;
        r.samples = '0;
        if (r.done) begin
            r.rms     = RootW'(floor_root(win_sum / 64'(win_cnt)));
            r.samples = win_cnt;
            win_sum   = '0;
            win_cnt   = '0;
            n_windows++;
        end
        r.magnitude = RootW'(floor_root(sq));
        expected_readings.push_back(r);
    endtask

    task automatic report_fault(string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        fault_count++;
    endtask

    task automatic check_reading();
        reading_t w;
        if (expected_readings.size() == 0) begin
            report_fault($sformatf("unexpected result tdata=%h tuser=%b", m_tdata, m_tuser));
            return;
        end
        w = expected_readings.pop_front();
        n_checked++;
        if (m_tdata[0 +: RootW] !== w.magnitude)
            report_fault($sformatf("magnitude %0d, want %0d", m_tdata[0 +: RootW], w.magnitude));
        if (m_tuser[0] !== w.show)
            report_fault($sformatf("show_sample %b, want %b", m_tuser[0], w.show));
        if (m_tuser[1] !== w.done)
            report_fault($sformatf("window_done %b, want %b", m_tuser[1], w.done));
        if (m_tdata[RootW +: RootW] !== w.rms)
            report_fault($sformatf("window rms %0d, want %0d",
                                   m_tdata[RootW +: RootW], w.rms));
        if (m_tdata[2*RootW +: WinW] !== w.samples)
            report_fault($sformatf("window_samples %0d, want %0d",
                                   m_tdata[2*RootW +: WinW], w.samples));
    endtask

    // ------------------------------------------------------------------
    // driver: presents queued sample requests, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            // register writes land in the model on the same edge as in the block
            if (cfg_we) begin
                case (cfg_index)
                    REG_WINDOW_LENGTH: win_len    = cfg_wdata;
                    REG_DISPLAY_EVERY: disp_every = cfg_wdata[DispW-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_reading(s_tdata, s_tuser[0]);
            // keep the current request until it is taken; then maybe idle
            if (!s_tvalid || s_tready) begin
                if (pending_samples.size() != 0 && !hold_sends &&
                    $urandom_range(99) >= idle_pct) begin
                    sample_req_t q;
                    q = pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {q.stamp, q.az, q.ay, q.ax};
                    s_tuser  <= q.ok;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random backpressure, checks each result taken
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_reading();
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_readings.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic push_sample(int x, int y, int z, logic [TimeW-1:0] t, logic ok);
        sample_req_t q;
        q.ax = AccelW'(x);
        q.ay = AccelW'(y);
        q.az = AccelW'(z);
        q.stamp = t;
        q.ok = ok;
        pending_samples.push_back(q);
    endtask

    // mostly full-range values, some rails and small values
    function automatic logic signed [AccelW-1:0] rand_axis();
        case ($urandom_range(9))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return '0;
            3:       return AccelW'($signed(AccelW'($urandom_range(15)))
                                    * ($urandom_range(1) ? 1 : -1));
            default: return AccelW'($urandom);
        endcase
    endfunction

    // mostly well-formed samples with fresh stamps; drop_pct are invalid,
    // repeated or zero stamps
    task automatic push_random(int count, int drop_pct);
        sample_req_t q;
        for (int i = 0; i < count; i++) begin
            q.ax = rand_axis();
            q.ay = rand_axis();
            q.az = rand_axis();
            q.ok = 1'b1;
            if ($urandom_range(99) < drop_pct) begin
                case ($urandom_range(2))
                    0: begin
                        q.ok    = 1'b0;
                        q.stamp = $urandom;
                    end
                    1: q.stamp = gen_stamp;
                    default: begin
                        q.stamp   = '0;
                        gen_stamp = '0;
                    end
                endcase
            end else begin
                if ($urandom_range(15) == 0) q.stamp = $urandom;
                else q.stamp = gen_stamp + $urandom_range(1, 40000);
                if (q.stamp == gen_stamp) q.stamp++;
                gen_stamp = q.stamp;
            end
            pending_samples.push_back(q);
        end
    endtask

    // wait until everything sent has been answered
    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_samples.size() != 0 || s_tvalid || expected_readings.size() != 0);
    endtask

    // writes only from idle; dropped samples may still be in flight, so let
    // the longest latency pass first
    task automatic set_config(logic [WinW-1:0] wl, logic [DispW-1:0] de);
        wait_drained();
        repeat (QuietCycles) @(posedge aclk);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_WINDOW_LENGTH;
        cfg_wdata <= wl;
        @(posedge aclk);
        cfg_index <= REG_DISPLAY_EVERY;
        cfg_wdata <= {3'($urandom_range(7)), de};   // upper bits must be ignored
        @(posedge aclk);
        cfg_we    <= 1'b0;
        n_settings++;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset settings (200, 10)
        push_sample(0, 0, 0, 32'd0, 1'b1);                     // stamp 0 right after reset: repeat
        push_sample(-32768, -32768, -32768, 32'd7, 1'b0);      // invalid report
        push_sample(-32768, -32768, -32768, 32'd1, 1'b1);      // largest magnitude
        push_sample(32767, 32767, 32767, 32'd2, 1'b1);
        push_sample(0, 0, 0, 32'd3, 1'b1);
        push_sample(1, 1, 1, 32'd3, 1'b1);                     // repeated stamp
        push_sample(-32768, 32767, 0, 32'd4, 1'b1);
        push_sample(-1, 1, -1, 32'd5, 1'b1);
        push_sample(3, 4, 0, 32'hFFFF_FFFF, 1'b1);             // top stamp
        push_sample(0, 0, -32768, 32'd0, 1'b1);                // stamp 0 now differs: kept
        push_sample(100, -200, 300, 32'd0, 1'b1);              // repeat of zero
        push_sample(5, 5, 5, 32'd6, 1'b0);
        gen_stamp = '0;

        // zero length / zero decimation: close and flag on every sample
        set_config(11'd0, 8'd0);
        push_random(10, 20);

        set_config(11'd1, 8'd1);
        push_random(100, 15);

        // length above max saturates to 1024; long stretch without gaps or stalls first, then
        // a pause until every result is back
        set_config(11'd2047, 8'd255);
        idle_pct = 0;
        push_random(1080, 3);
        while (pending_samples.size() > 780) @(negedge aclk);
        idle_pct = IdlePct;
        while (pending_samples.size() > 540) @(negedge aclk);
        hold_sends = 1'b1;
        do @(negedge aclk);
        while (s_tvalid || expected_readings.size() != 0);
        repeat (QuietCycles) @(posedge aclk);
        hold_sends = 1'b0;

        set_config(11'd1024, 8'd7);
        push_random(60, 15);

        set_config(11'd3, 8'd254);
        push_random(150, 15);

        wait_drained();
        repeat (QuietCycles) @(posedge aclk);

        $display("covered %0d kept and %0d dropped samples, %0d results, %0d windows closed",
                 n_accepted, n_dropped, n_checked, n_windows);
        $display("over %0d register settings; %0d mismatches", n_settings, fault_count);
        if (fault_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
